// File: sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/wavhp_pkg.sv
// Types, constants and command/status structs of the WAVE header parser.
package wavhp_pkg;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 136;

  localparam logic [5:0]  MIN_FILE_LEN = 6'd44;
  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
  localparam logic [4:0]  MAGIC_LEN    = 5'd12;
  localparam logic [31:0] TAG_FMT      = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
  // magic words, first file byte in the lowest bits
  localparam logic [31:0] RIFF_WORD    = 32'h4646_4952;
  localparam logic [31:0] WAVE_WORD    = 32'h4556_4157;
  localparam logic [15:0] FMT_TAG_PCM  = 16'd1;

  localparam logic [1:0]  FMT_CODE_PCM   = 2'd0;
  localparam logic [1:0]  FMT_CODE_OTHER = 2'd3;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned DIVISOR_W = 29;

  typedef enum logic [1:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic accept;     // a byte request is taken this cycle
    logic last_item;  // that byte ends the file
    logic mul;        // form the divisor from the snapshot
    logic div_step;   // one quotient bit
    logic load;       // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic div_last;   // current step is the final quotient bit
  } status_t;

endpackage

// File: sv/wavhp_ctrl.sv
// Controller: byte acceptance, divide sequencing and output register handshake.
module wavhp_ctrl
  import wavhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_tlast,
  input  logic    out_tready,
  input  status_t sts,
  output logic    in_tready,
  output logic    out_tvalid,
  output cmd_t    cmd
);

  ctrl_state_t st_r, st_nxt;
  logic        out_full_r, out_full_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_RUN;
      out_full_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (st_r)
      ST_RUN: begin
        in_tready     = 1'b1;
        cmd.accept    = in_tvalid;
        cmd.last_item = in_tvalid && in_tlast;
        if (in_tvalid && in_tlast) st_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        st_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) st_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the previous result has left
        if (!out_full_r || out_tready) begin
          cmd.load = 1'b1;
          st_nxt   = ST_RUN;
        end
      end
      default: st_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    if (cmd.load) out_full_nxt = 1'b1;
    else if (out_tready) out_full_nxt = 1'b0;
    else out_full_nxt = out_full_r;
  end

  assign out_tvalid = out_full_r;

endmodule

// File: sv/wavhp_dp.sv
// Datapath: chunk walker registers, result snapshot, serial divider, output register.
module wavhp_dp
  import wavhp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output status_t               sts,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [7:0] b;
  assign b = in_tdata[7:0];

  // walker state
  phase_t      phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [5:0]  len_seen_r, len_seen_nxt;
  logic        magic_r, magic_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [7:0]  stg_r [16];
  logic        stg_we;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        pcm_r, pcm_nxt;
  logic        fmt_r, fmt_nxt;
  logic [31:0] dsize_r, dsize_nxt;

  logic [31:0] len_full;
  logic [32:0] skip_new;
  logic        hdr_ok;

  assign len_full = {b, clen_r[23:0]};
  assign skip_new = {1'b0, len_full} + {32'd0, len_full[0]};

  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    len_seen_nxt = (len_seen_r < MIN_FILE_LEN) ? len_seen_r + 6'd1 : len_seen_r;
    magic_nxt    = magic_r;
    tag_nxt      = tag_r;
    clen_nxt     = clen_r;
    skip_nxt     = skip_r;
    stg_we       = 1'b0;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    pcm_nxt      = pcm_r;
    fmt_nxt      = fmt_r;
    dsize_nxt    = dsize_r;
    unique case (phase_r)
      PH_MAGIC: begin
        if (idx_r < 5'd4 && b != RIFF_WORD[8*idx_r[1:0] +: 8]) magic_nxt = 1'b0;
        if (idx_r[4:2] == 3'b010 && b != WAVE_WORD[8*idx_r[1:0] +: 8]) magic_nxt = 1'b0;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == MAGIC_LEN - 5'd1) begin
          phase_nxt = PH_HEADER;
          idx_nxt   = 5'd0;
          tag_nxt   = '0;
          clen_nxt  = '0;
        end
      end
      PH_HEADER: begin
        unique case (idx_r[2:0])
          3'd0: tag_nxt[7:0]    = b;
          3'd1: tag_nxt[15:8]   = b;
          3'd2: tag_nxt[23:16]  = b;
          3'd3: tag_nxt[31:24]  = b;
          3'd4: clen_nxt[7:0]   = b;
          3'd5: clen_nxt[15:8]  = b;
          3'd6: clen_nxt[23:16] = b;
          3'd7: clen_nxt[31:24] = b;
          default: ;
        endcase
        idx_nxt = idx_r + 5'd1;
        if (idx_r[2:0] == 3'd7) begin
          if (tag_r == TAG_DATA) begin
            dsize_nxt = len_full;
            phase_nxt = PH_DONE;
          end else begin
            skip_nxt = skip_new;
            idx_nxt  = 5'd0;
            if (len_full == 32'd0) begin
              tag_nxt  = '0;
              clen_nxt = '0;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        if (tag_r == TAG_FMT && clen_r >= FMT_MIN_LEN && idx_r < 5'd16) begin
          stg_we  = 1'b1;
          idx_nxt = idx_r + 5'd1;
          if (idx_r == 5'd15) begin
            chan_nxt = {stg_r[3], stg_r[2]};
            rate_nxt = {stg_r[7], stg_r[6], stg_r[5], stg_r[4]};
            bits_nxt = {b, stg_r[14]};
            pcm_nxt  = ({stg_r[1], stg_r[0]} == FMT_TAG_PCM);
            fmt_nxt  = 1'b1;
          end
        end
        skip_nxt = skip_r - 33'd1;
        if (skip_r == 33'd1) begin
          phase_nxt = PH_HEADER;
          idx_nxt   = 5'd0;
          tag_nxt   = '0;
          clen_nxt  = '0;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.accept && cmd.last_item)) begin
      // a finished file restarts the walker
      phase_r    <= PH_MAGIC;
      idx_r      <= '0;
      len_seen_r <= '0;
      magic_r    <= 1'b1;
      tag_r      <= '0;
      clen_r     <= '0;
      skip_r     <= '0;
      chan_r     <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
      pcm_r      <= 1'b0;
      fmt_r      <= 1'b0;
      dsize_r    <= '0;
    end else if (cmd.accept) begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      len_seen_r <= len_seen_nxt;
      magic_r    <= magic_nxt;
      tag_r      <= tag_nxt;
      clen_r     <= clen_nxt;
      skip_r     <= skip_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      pcm_r      <= pcm_nxt;
      fmt_r      <= fmt_nxt;
      dsize_r    <= dsize_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && stg_we) stg_r[idx_r[3:0]] <= b;
  end

  // result snapshot, already masked
  logic        res_hdr_r, res_fmt_r;
  logic [1:0]  res_code_r;
  logic [15:0] res_chan_r, res_bits_r;
  logic [31:0] res_rate_r, res_data_r;

  assign hdr_ok = (len_seen_nxt >= MIN_FILE_LEN) && magic_nxt;

  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.last_item) begin
      res_hdr_r  <= hdr_ok;
      res_fmt_r  <= hdr_ok && fmt_nxt;
      res_code_r <= (hdr_ok && fmt_nxt && !pcm_nxt) ? FMT_CODE_OTHER : FMT_CODE_PCM;
      res_chan_r <= (hdr_ok && fmt_nxt) ? chan_nxt : 16'd0;
      res_rate_r <= (hdr_ok && fmt_nxt) ? rate_nxt : 32'd0;
      res_bits_r <= (hdr_ok && fmt_nxt) ? bits_nxt : 16'd0;
      res_data_r <= hdr_ok ? dsize_nxt : 32'd0;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DIVISOR_W-1:0] div_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [31:0]          quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[31]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      div_r <= {16'd0, res_bits_r[15:3]} * {13'd0, res_chan_r};
      rem_r <= '0;
      quo_r <= res_data_r;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_r <= {quo_r[30:0], ge};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  assign sts.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // output register
  logic cnt_ok;
  assign cnt_ok = (div_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_tdata <= {3'b000, cnt_ok, cnt_ok ? quo_r : 32'd0, res_data_r, res_bits_r,
                    res_rate_r, res_chan_r, res_code_r, res_fmt_r, res_hdr_r};
    end
  end

endmodule

// File: sv/wav_header_parser_unit.sv
// Top level of the RIFF/WAVE header parser.
//
//  channel | ports                      | payload
//  --------+----------------------------+------------------------------------------
//  input   | in_tvalid/in_tready        | in_tdata = file_byte, in_tlast = final_byte
//  result  | out_tvalid/out_tready      | out_tdata = 133 bits of header metadata
//
// A non-final byte never stalls the input, so bytes stream at one per cycle within a file.
// After the final byte in_tready stays low while the controller forms the divisor,
// runs the bit-serial frame count division and loads the output register, and also
// while the previous result still waits for out_tready.
// Reset (rst_n low, synchronous) clears the walker and empties the output register.
module wav_header_parser_unit
  import wavhp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] file_byte
  input  logic                  in_tlast,   // final_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] header_valid, [1] fmt_found, [3:2] format_code, [19:4] channel_count,
  // [51:20] sample_rate, [67:52] sample_bits, [99:68] data_bytes,
  // [131:100] frame_count, [132] count_valid, [135:133] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cmd_t    cmd;
  status_t sts;

  wavhp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  wavhp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

// File: sv/wavhp_checker.sv
// Port-level checker of the WAVE header parser, bound to the top level.
`include "assert_macros.svh"

module wavhp_checker
  import wavhp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `ASSERT_IMPL(a_bad_hdr_zero, out_tvalid && !out_tdata[0], out_tdata[135:1] == '0, "invalid header with nonzero fields")
  `ASSERT_IMPL(a_no_fmt_zero, out_tvalid && !out_tdata[1], out_tdata[67:2] == '0, "format fields set without fmt chunk")
  `ASSERT_IMPL(a_no_count_zero, out_tvalid && !out_tdata[132], out_tdata[131:100] == '0, "frame count set without valid divisor")

endmodule

bind wav_header_parser_unit wavhp_checker u_wavhp_checker (.*);

// File: test/wav_header_parser_unit_test.sv
// Self-checking testbench for the RIFF/WAVE header parser: byte streams in, metadata checked out.
module wav_header_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wavhp_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned ITEM_TARGET  = 1500;
  // eight random files at the end, about 55 bytes each
  localparam int unsigned TAIL_ITEMS   = 440;
  localparam int unsigned MIN_FILES    = 24;

  // out_tdata layout, top bits first
  typedef struct packed {
    logic [2:0]  spare;
    logic        count_valid;
    logic [31:0] frame_count;
    logic [31:0] data_bytes;
    logic [15:0] sample_bits;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [1:0]  format_code;
    logic        fmt_found;
    logic        header_valid;
  } header_meta_t;

  class wav_scoreboard;
    phase_t       phase;
    int unsigned  field_idx;
    int unsigned  bytes_seen;
    bit           magic_ok;
    logic [31:0]  chunk_id;
    logic [31:0]  chunk_len;
    logic [32:0]  skip_left;
    logic [7:0]   fmt_bytes [16];
    logic [15:0]  fmt_channels;
    logic [31:0]  fmt_rate;
    logic [15:0]  fmt_bits;
    bit           fmt_pcm;
    bit           fmt_valid;
    logic [31:0]  data_len;
    header_meta_t pending_meta [$];
    int unsigned  failures = 0;
    int unsigned  results = 0;
    int unsigned  files = 0;
    int unsigned  sent_bytes = 0;
    int unsigned  walked_bytes = 0;
    int unsigned  valid_headers = 0;
    int unsigned  fmt_files = 0;
    int unsigned  counted_files = 0;

    function new();
      clear_walker();
    endfunction

    function void clear_walker();
      phase = PH_MAGIC;
      field_idx = 0;
      bytes_seen = 0;
      magic_ok = 1'b1;
      chunk_id = '0;
      chunk_len = '0;
      skip_left = '0;
      foreach (fmt_bytes[k]) fmt_bytes[k] = '0;
      fmt_channels = '0;
      fmt_rate = '0;
      fmt_bits = '0;
      fmt_pcm = 1'b0;
      fmt_valid = 1'b0;
      data_len = '0;
    endfunction

    function void open_header();
      phase = PH_HEADER;
      field_idx = 0;
      chunk_id = '0;
      chunk_len = '0;
    endfunction

    function void walk_byte(logic [7:0] b);
      int unsigned k;
      if (bytes_seen < MIN_FILE_LEN) bytes_seen++;
      case (phase)
        PH_MAGIC: begin
          if (field_idx < 4 && b != RIFF_WORD[8*field_idx +: 8]) magic_ok = 1'b0;
          if (field_idx >= 8 && field_idx < 12 && b != WAVE_WORD[8*(field_idx-8) +: 8])
            magic_ok = 1'b0;
          field_idx++;
          if (field_idx >= MAGIC_LEN) open_header();
        end
        PH_HEADER: begin
          k = field_idx & 7;
          if (k < 4) chunk_id[8*k +: 8] = b;
          else chunk_len[8*(k-4) +: 8] = b;
          field_idx = k + 1;
          if (field_idx == 8) begin
            if (chunk_id == TAG_DATA) begin
              data_len = chunk_len;
              phase = PH_DONE;
            end else begin
              // body plus pad byte when the size is odd
              skip_left = {1'b0, chunk_len} + chunk_len[0];
              field_idx = 0;
              if (skip_left == 0) open_header();
              else phase = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (chunk_id == TAG_FMT && chunk_len >= FMT_MIN_LEN && field_idx < FMT_MIN_LEN) begin
            fmt_bytes[field_idx] = b;
            field_idx++;
            if (field_idx == FMT_MIN_LEN) begin
              fmt_channels = {fmt_bytes[3], fmt_bytes[2]};
              fmt_rate = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
              fmt_bits = {fmt_bytes[15], fmt_bytes[14]};
              fmt_pcm = ({fmt_bytes[1], fmt_bytes[0]} == FMT_TAG_PCM);
              fmt_valid = 1'b1;
            end
          end
          if (skip_left != 0) skip_left = skip_left - 1;
          if (skip_left == 0) open_header();
        end
        default: ;
      endcase
    endfunction

    // Walk one accepted byte; the final byte of a file queues the expected metadata.
    function void note_byte(logic [7:0] b, logic last);
      header_meta_t m;
      logic [31:0]  divisor;
      sent_bytes++;
      if (phase != PH_DONE) walked_bytes++;
      walk_byte(b);
      if (!last) return;
      m = '0;
      if (bytes_seen >= MIN_FILE_LEN && magic_ok) begin
        divisor = 32'(fmt_bits / 8) * 32'(fmt_channels);
        m.header_valid = 1'b1;
        valid_headers++;
        if (fmt_valid) begin
          m.fmt_found = 1'b1;
          m.format_code = fmt_pcm ? FMT_CODE_PCM : FMT_CODE_OTHER;
          m.channel_count = fmt_channels;
          m.sample_rate = fmt_rate;
          m.sample_bits = fmt_bits;
          fmt_files++;
        end
        m.data_bytes = data_len;
        if (divisor != 0) begin
          m.frame_count = data_len / divisor;
          m.count_valid = 1'b1;
          counted_files++;
        end
      end
      pending_meta.push_back(m);
      files++;
      clear_walker();
    endfunction

    function void log_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function string describe(header_meta_t m);
      return $sformatf("hv=%0d fmt=%0d code=%0d ch=%0d rate=%0h bits=%0d size=%0h frames=%0h cv=%0d",
                       m.header_valid, m.fmt_found, m.format_code, m.channel_count,
                       m.sample_rate, m.sample_bits, m.data_bytes, m.frame_count,
                       m.count_valid);
    endfunction

    function void check_result(header_meta_t got);
      header_meta_t want;
      string        diffs;
      results++;
      if (pending_meta.size() == 0) begin
        log_failure($sformatf("result %0d arrived with no file pending: %s",
                              results, describe(got)));
        return;
      end
      want = pending_meta.pop_front();
      diffs = "";
      if (got.header_valid !== want.header_valid) diffs = {diffs, " header_valid"};
      if (got.fmt_found !== want.fmt_found) diffs = {diffs, " fmt_found"};
      if (got.format_code !== want.format_code) diffs = {diffs, " format_code"};
      if (got.channel_count !== want.channel_count) diffs = {diffs, " channel_count"};
      if (got.sample_rate !== want.sample_rate) diffs = {diffs, " sample_rate"};
      if (got.sample_bits !== want.sample_bits) diffs = {diffs, " sample_bits"};
      if (got.data_bytes !== want.data_bytes) diffs = {diffs, " data_bytes"};
      if (got.frame_count !== want.frame_count) diffs = {diffs, " frame_count"};
      if (got.count_valid !== want.count_valid) diffs = {diffs, " count_valid"};
      if (diffs != "")
        log_failure($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                              results, diffs, describe(want), describe(got)));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  wav_scoreboard sb = new();
  logic [7:0]    file_q [$];
  bit            src_idle;
  bit            sink_idle;
  int unsigned   hold_request;

  wav_header_parser_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(header_meta_t'(out_tdata));
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // Result receiver: random stall bursts, plus one long hold on request.
  initial begin : sink
    int unsigned hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
      end else if (hold == 0 && sink_idle && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 19);
      end
      if (hold != 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void put_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) file_q.push_back(w[8*k +: 8]);
  endfunction

  function automatic void put_noise(int unsigned n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  function automatic void put_riff();
    put_word(RIFF_WORD);
    put_word($urandom);
    put_word(WAVE_WORD);
  endfunction

  // short bodies only
  function automatic void put_chunk(logic [31:0] id, logic [31:0] len);
    put_word(id);
    put_word(len);
    put_noise(len + len[0]);
  endfunction

  function automatic void put_fmt(logic [31:0] len, logic [15:0] tag, logic [15:0] chans,
                                  logic [31:0] rate, logic [15:0] bits);
    logic [127:0] body;
    body = {bits, 16'($urandom), 32'($urandom), rate, chans, tag};
    put_word(TAG_FMT);
    put_word(len);
    for (int k = 0; k < 16 && k < len; k++) file_q.push_back(body[8*k +: 8]);
    if (len > 16) put_noise(len - 16);
    put_noise(len[0]);
  endfunction

  function automatic void put_data(logic [31:0] len);
    put_word(TAG_DATA);
    put_word(len);
  endfunction

  function automatic void put_random_fmt();
    logic [15:0] chans;
    logic [15:0] bits;
    case ($urandom_range(0, 7))
      0: chans = '0;
      1: chans = 16'($urandom);
      default: chans = 16'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 7))
      0: bits = 16'($urandom);
      1: bits = 16'($urandom_range(0, 7));
      default: bits = 16'(8 * $urandom_range(1, 4));
    endcase
    put_fmt($urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 24)) : FMT_MIN_LEN,
            $urandom_range(0, 1) ? FMT_TAG_PCM : 16'($urandom), chans, $urandom, bits);
  endfunction

  // Mostly well-formed files with random content; the rest broken or pure noise.
  function automatic void build_random_file();
    int unsigned shape;
    int unsigned keep;
    shape = $urandom_range(0, 9);
    put_riff();
    repeat ($urandom_range(0, 2))
      put_chunk($urandom_range(0, 3) == 0 ? TAG_FMT : 32'($urandom), $urandom_range(0, 7));
    if ($urandom_range(0, 5) != 0) put_random_fmt();
    if ($urandom_range(0, 5) == 0) put_random_fmt();
    if ($urandom_range(0, 7) != 0) begin
      put_data($urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 4096)));
      put_noise($urandom_range(0, 8));
    end
    case (shape)
      0: file_q[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
      1: begin
        keep = $urandom_range(1, file_q.size());
        while (file_q.size() > keep) file_q.delete(file_q.size() - 1);
      end
      2: begin
        file_q.delete();
        put_noise($urandom_range(1, 60));
      end
      default: ;
    endcase
  endfunction

  task automatic send_file();
    if (file_q.size() == 0) file_q.push_back(8'($urandom));
    foreach (file_q[k]) begin
      logic last_byte;
      last_byte = (k == file_q.size() - 1);
      if (src_idle && $urandom_range(0, 11) == 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end
      @(negedge clk);
      in_tvalid <= 1'b1;
      in_tdata <= file_q[k];
      in_tlast <= last_byte;
      do @(posedge clk); while (!in_tready);
      sb.note_byte(file_q[k], last_byte);
    end
    file_q.delete();
  endtask

  // Withdraw the request and hold until every expected result is in.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_meta.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    hold_request = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // canonical 44-byte PCM file
    put_riff();
    put_fmt(FMT_MIN_LEN, FMT_TAG_PCM, 16'd2, 32'd44100, 16'd16);
    put_data(32'd176400);
    send_file();
    // same file one byte short of the minimum length
    put_riff();
    put_fmt(FMT_MIN_LEN, FMT_TAG_PCM, 16'd2, 32'd44100, 16'd16);
    put_data(32'd176400);
    file_q.delete(file_q.size() - 1);
    send_file();
    // broken RIFF word, then broken WAVE word
    put_riff();
    file_q[0] = 8'h00;
    put_fmt(FMT_MIN_LEN, FMT_TAG_PCM, 16'd1, 32'd8000, 16'd8);
    put_data(32'd800);
    send_file();
    put_riff();
    file_q[11] = 8'h00;
    put_fmt(FMT_MIN_LEN, FMT_TAG_PCM, 16'd1, 32'd8000, 16'd8);
    put_data(32'd800);
    send_file();
    // non-PCM tag with every field at its maximum
    put_riff();
    put_fmt(FMT_MIN_LEN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_data(32'hFFFF_FFFF);
    send_file();
    // zero divisor: samples under one byte, then no channels
    put_riff();
    put_fmt(FMT_MIN_LEN, FMT_TAG_PCM, 16'd1, 32'd8000, 16'd7);
    put_data(32'd100);
    send_file();
    put_riff();
    put_fmt(FMT_MIN_LEN, FMT_TAG_PCM, 16'd0, 32'd8000, 16'd16);
    put_data(32'd100);
    send_file();
    // odd and empty chunks ahead of an odd-sized fmt; bytes after the data header are ignored
    put_riff();
    put_chunk(32'h5453_494c, 32'd3);
    put_chunk(32'h6b6e_756a, 32'd0);
    put_fmt(32'd17, 16'd3, 16'd6, 32'd96000, 16'd24);
    put_data(32'd5000);
    put_noise(9);
    send_file();
    // fmt chunk below the minimum size, no data chunk
    put_riff();
    put_fmt(32'd15, FMT_TAG_PCM, 16'd2, 32'd22050, 16'd8);
    put_noise(20);
    send_file();
    // a later complete fmt replaces the earlier one
    put_riff();
    put_fmt(FMT_MIN_LEN, FMT_TAG_PCM, 16'd1, 32'd8000, 16'd8);
    put_fmt(32'd18, FMT_TAG_PCM, 16'd2, 32'd16000, 16'd16);
    put_data(32'd64);
    send_file();
    // second fmt cut off after ten body bytes: the first one stands
    put_riff();
    put_fmt(FMT_MIN_LEN, FMT_TAG_PCM, 16'd4, 32'd32000, 16'd32);
    put_fmt(FMT_MIN_LEN, FMT_TAG_PCM, 16'd8, 32'd1, 16'd8);
    repeat (6) file_q.delete(file_q.size() - 1);
    send_file();
    // empty data chunk and no fmt
    put_riff();
    put_data(32'd0);
    put_noise(24);
    send_file();
    // huge odd chunk cut off by the end of file
    put_riff();
    put_word($urandom);
    put_word(32'hFFFF_FFFF);
    put_noise(40);
    send_file();
    // one-byte file, then all ones and all zeros
    file_q.push_back(RIFF_WORD[7:0]);
    send_file();
    repeat (48) file_q.push_back(8'hFF);
    send_file();
    repeat (48) file_q.push_back(8'h00);
    send_file();

    // long receiver hold while short files keep coming, then let everything drain
    @(posedge clk);
    hold_request = LONG_HOLD;
    repeat (4) begin
      put_noise($urandom_range(1, 12));
      send_file();
    end
    drain_results();

    while (sb.sent_bytes < ITEM_TARGET - TAIL_ITEMS || sb.files < MIN_FILES) begin
      build_random_file();
      send_file();
    end
    src_idle = 1'b0;
    sink_idle = 1'b0;
    repeat (8) begin
      build_random_file();
      send_file();
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d files (%0d bytes, %0d walked): %0d valid headers, %0d with fmt, %0d counted.",
             sb.files, sb.sent_bytes, sb.walked_bytes, sb.valid_headers, sb.fmt_files,
             sb.counted_files);
    $display("Checked %0d results with %0d failures.", sb.results, sb.failures);
    if (sb.failures == 0 && sb.pending_meta.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (sb.pending_meta.size() != 0)
        $display("%0d expected results never arrived", sb.pending_meta.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
